// ===== hw/rtl/ftba_pkg.sv =====
package ftba_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int COLOR_W       = 8;
   localparam int THR_W         = 17;
   localparam int CSR_IDX_W     = 2;

   localparam logic [THR_W-1:0]   THR_RESET = 17'd62259;
   localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD,
      CSR_BG_RED,
      CSR_BG_GREEN,
      CSR_BG_BLUE
   } csr_idx_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } color_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic est;
      logic fix;
      logic cmul;
      logic acc;
      logic bgmul;
      logic fin;
   } dp_cmd_type;

   typedef struct packed {
      logic term;
   } dp_stat_type;

endpackage

// ===== hw/rtl/ftba_ifs.sv =====
interface ftba_req_if import ftba_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] layer_red;
   logic [COLOR_W-1:0] layer_green;
   logic [COLOR_W-1:0] layer_blue;
   logic [COLOR_W-1:0] layer_alpha;
   logic               last_layer;

   modport source (output valid, layer_red, layer_green, layer_blue, layer_alpha, last_layer,
                   input ready);
   modport sink (input valid, layer_red, layer_green, layer_blue, layer_alpha, last_layer,
                 output ready);
endinterface

interface ftba_rsp_if import ftba_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] out_red;
   logic [COLOR_W-1:0] out_green;
   logic [COLOR_W-1:0] out_blue;
   logic [COLOR_W-1:0] out_alpha;

   modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface ftba_csr_if import ftba_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [THR_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ftba_dp.sv =====
module ftba_dp import ftba_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_stat_type        stat,
   input  color_type          layer_color,
   input  logic [COLOR_W-1:0] layer_alpha,
   input  logic [THR_W-1:0]   threshold,
   input  color_type          background,
   output logic [COLOR_W-1:0] out_red,
   output logic [COLOR_W-1:0] out_green,
   output logic [COLOR_W-1:0] out_blue,
   output logic [COLOR_W-1:0] out_alpha
);

   localparam int OP_W  = FRAC_BITS + 1;
   localparam int SUM_W = FRAC_BITS + COLOR_W + 1;
   localparam int X_W   = OP_W + COLOR_W;
   localparam int Y_W   = X_W + 1;
   localparam int NT    = (X_W + COLOR_W - 1) / COLOR_W + 1;
   localparam int CMP_W = (OP_W > THR_W) ? OP_W : THR_W;

   localparam logic [OP_W-1:0] ONE_FIX = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [X_W-1:0]  DIV_K   = X_W'(COLOR_MAX);

   color_type          col_ff;
   logic [COLOR_W-1:0] alpha_ff;
   logic [X_W-1:0]     x_ff;
   logic [OP_W-1:0]    q_ff;
   logic [OP_W-1:0]    w_ff;
   logic [SUM_W-1:0]   pr_ff, pg_ff, pb_ff;
   logic [SUM_W-1:0]   tr_ff, tg_ff, tb_ff;
   logic [SUM_W-1:0]   sr_ff, sg_ff, sb_ff;
   logic [OP_W-1:0]    op_ff;
   logic               term_ff;
   logic [COLOR_W-1:0] or_ff, og_ff, ob_ff, oa_ff;

   logic [OP_W-1:0]    trans;
   logic [X_W-1:0]     x_in;
   logic [Y_W-1:0]     y;
   logic [OP_W-1:0]    q_in;
   logic [X_W-1:0]     rem;
   logic [OP_W-1:0]    w_in;
   logic [SUM_W-1:0]   alpha_scaled;
   logic               over_thr;

   function automatic logic [COLOR_W-1:0] sat_color(input logic [SUM_W-1:0] sum,
                                                     input logic [SUM_W-1:0] bg_part);
      logic [SUM_W:0] v;
      logic [SUM_W:0] s;
      v = (SUM_W+1)'(sum) + (SUM_W+1)'(bg_part);
      s = v >> FRAC_BITS;
      return (s > (SUM_W+1)'(COLOR_MAX)) ? COLOR_MAX : s[COLOR_W-1:0];
   endfunction

   assign trans = ONE_FIX - op_ff;
   assign x_in  = X_W'(trans) * X_W'(alpha_ff);

   always_comb begin
      y = '0;
      for (int k = 0; k < NT; k++) begin
         y = y + Y_W'(x_ff >> (COLOR_W * k));
      end
   end

   assign q_in         = y[COLOR_W +: OP_W];
   assign rem          = x_ff - ((X_W'(q_ff) << COLOR_W) - X_W'(q_ff));
   assign w_in         = q_ff + OP_W'(rem >= DIV_K);
   assign over_thr     = CMP_W'(op_ff) > CMP_W'(threshold);
   assign alpha_scaled = (SUM_W'(op_ff) << COLOR_W) - SUM_W'(op_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff   <= layer_color;
         alpha_ff <= layer_alpha;
      end
      if (cmd.mul) begin
         x_ff <= x_in;
      end
      if (cmd.est) begin
         q_ff <= q_in;
      end
      if (cmd.fix) begin
         w_ff <= w_in;
      end
      if (cmd.cmul) begin
         pr_ff <= SUM_W'(w_ff) * SUM_W'(col_ff.red);
         pg_ff <= SUM_W'(w_ff) * SUM_W'(col_ff.green);
         pb_ff <= SUM_W'(w_ff) * SUM_W'(col_ff.blue);
      end
      if (cmd.bgmul) begin
         tr_ff <= SUM_W'(trans) * SUM_W'(background.red);
         tg_ff <= SUM_W'(trans) * SUM_W'(background.green);
         tb_ff <= SUM_W'(trans) * SUM_W'(background.blue);
      end
      if (cmd.fin) begin
         or_ff <= sat_color(sr_ff, tr_ff);
         og_ff <= sat_color(sg_ff, tg_ff);
         ob_ff <= sat_color(sb_ff, tb_ff);
         oa_ff <= alpha_scaled[FRAC_BITS +: COLOR_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.fin) begin
         sr_ff   <= '0;
         sg_ff   <= '0;
         sb_ff   <= '0;
         op_ff   <= '0;
         term_ff <= 1'b0;
      end else begin
         if (cmd.cmul) begin
            op_ff <= op_ff + w_ff;
         end
         if (cmd.acc) begin
            sr_ff   <= sr_ff + pr_ff;
            sg_ff   <= sg_ff + pg_ff;
            sb_ff   <= sb_ff + pb_ff;
            term_ff <= term_ff | over_thr;
         end
      end
   end

   assign stat.term = term_ff;
   assign out_red   = or_ff;
   assign out_green = og_ff;
   assign out_blue  = ob_ff;
   assign out_alpha = oa_ff;

endmodule

// ===== hw/rtl/ftba_ctrl.sv =====
module ftba_ctrl import ftba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_EST,
      ST_FIX,
      ST_CMUL,
      ST_ACC,
      ST_BGMUL,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               last_in  = req_last;
               if (!stat.term) begin
                  state_in = ST_MUL;
               end else if (req_last) begin
                  state_in = ST_BGMUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_EST;
         end
         ST_EST: begin
            cmd.est  = 1'b1;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_CMUL;
         end
         ST_CMUL: begin
            cmd.cmul = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = last_ff ? ST_BGMUL : ST_IDLE;
         end
         ST_BGMUL: begin
            cmd.bgmul = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.fin      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/front_to_back_alpha_compositor.sv =====
// Channel   Dir  Handshake          Payload
// req_bus   in   valid / ready      layer_red, layer_green, layer_blue, layer_alpha, last_layer
// rsp_bus   out  valid / ready      out_red, out_green, out_blue, out_alpha
// csr_bus   in   valid / ready      index, data (threshold 17 bits, background bytes)
//
// A layer goes through accept, opacity multiply, two reciprocal divide steps by 255, color
// multiply, accumulate; the rearmost layer adds background multiply and output load. After
// early termination a layer is only accepted, and the rearmost then gets those two steps.
// Reset clears the sums, the termination flag and the handshakes; the threshold and
// background registers take their reset values. csr_bus is always ready. One output
// register holds a result while the next pixel proceeds; only its output load waits for it.
module front_to_back_alpha_compositor import ftba_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   ftba_req_if.sink   req_bus,
   ftba_rsp_if.source rsp_bus,
   ftba_csr_if.sink   csr_bus
);

   logic [THR_W-1:0] thr_ff;
   color_type        bg_ff;
   dp_cmd_type       cmd;
   dp_stat_type      stat;
   color_type        layer_color;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         bg_ff  <= '0;
      end else if (csr_bus.valid) begin
         case (csr_idx_type'(csr_bus.index))
            CSR_THRESHOLD: thr_ff       <= csr_bus.data;
            CSR_BG_RED:    bg_ff.red    <= csr_bus.data[COLOR_W-1:0];
            CSR_BG_GREEN:  bg_ff.green  <= csr_bus.data[COLOR_W-1:0];
            CSR_BG_BLUE:   bg_ff.blue   <= csr_bus.data[COLOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign layer_color.red   = req_bus.layer_red;
   assign layer_color.green = req_bus.layer_green;
   assign layer_color.blue  = req_bus.layer_blue;

   ftba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req_last  (req_bus.last_layer),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ftba_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .layer_color (layer_color),
      .layer_alpha (req_bus.layer_alpha),
      .threshold   (thr_ff),
      .background  (bg_ff),
      .out_red     (rsp_bus.out_red),
      .out_green   (rsp_bus.out_green),
      .out_blue    (rsp_bus.out_blue),
      .out_alpha   (rsp_bus.out_alpha)
   );

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("datapath commands overlap");

   a_term_skip: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && stat.term && !req_bus.last_layer) |=> req_bus.ready)
      else $error("terminated layer started datapath work");

   a_rsp_after_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(cmd.fin))
      else $error("result shown without output load");

endmodule
